>>> rtl/gckm_pkg.sv
// ============================================================================
// gckm_pkg
// shared types, constants and keyword tables for the keyword matcher
// ============================================================================
package gckm_pkg;

    localparam int ByteW       = 8;
    localparam int TeamW       = 14;
    localparam int CodeW       = 5;
    localparam int DigitW      = 4;
    localparam int DigitCount  = 4;

    localparam int KwCount     = 21;
    localparam int TeamKwCount = 20;
    localparam int KwMaxLen    = 21;
    localparam int TextW       = KwMaxLen * ByteW;

    // first byte of the team digits inside "CMD,dddd,..."
    localparam int TeamDigitPos = 4;

    localparam int LongestKeywordDefault = 21;

    localparam logic [TeamW-1:0]  TeamReset   = TeamW'(1008);
    localparam logic [TeamW-1:0]  TeamModulus = TeamW'(10000);
    localparam logic [CodeW-1:0]  CodeNone    = '0;
    localparam logic [ByteW-1:0]  ByteEnd     = '0;
    localparam logic [DigitW-1:0] AsciiDigitHi = 4'h3;

    typedef logic [DigitCount-1:0][DigitW-1:0] team_digits_t;

    // per-transaction control from the input stage to the matcher
    typedef struct packed {
        logic advance;
        logic last;
    } gckm_step_t;

    // keyword text, team digits shown as zero placeholders
    function automatic logic [TextW-1:0] kw_text(input int k);
        case (k)
            0:       return TextW'("CMD,0000,CX,ON");
            1:       return TextW'("CMD,0000,CX,OFF");
            2:       return TextW'("CMD,0000,CAL");
            3:       return TextW'("CMD,0000,ST");
            4:       return TextW'("CMD,0000,RLS90");
            5:       return TextW'("CMD,0000,RLS0");
            6:       return TextW'("CMD,0000,PRC90");
            7:       return TextW'("CMD,0000,PRC0");
            8:       return TextW'("CMD,0000,RHS");
            9:       return TextW'("CMD,0000,RFS");
            10:      return TextW'("CMD,0000,CF");
            11:      return TextW'("CMD,0000,UHS");
            12:      return TextW'("CMD,0000,CHS");
            13:      return TextW'("CMD,0000,CAM,ON");
            14:      return TextW'("CMD,0000,CAM,OFF");
            15:      return TextW'("CMD,0000,BUZ,ON");
            16:      return TextW'("CMD,0000,BUZ,OFF");
            17:      return TextW'("CMD,0000,SIM,ENABLE");
            18:      return TextW'("CMD,0000,SIM,ACTIVATE");
            19:      return TextW'("CMD,0000,SIM,DISABLE");
            default: return TextW'("SIMP");
        endcase
    endfunction

    function automatic int kw_len(input int k);
        case (k)
            0:       return 14;
            1:       return 15;
            2:       return 12;
            3:       return 11;
            4:       return 14;
            5:       return 13;
            6:       return 14;
            7:       return 13;
            8:       return 12;
            9:       return 12;
            10:      return 11;
            11:      return 12;
            12:      return 12;
            13:      return 15;
            14:      return 16;
            15:      return 15;
            16:      return 16;
            17:      return 19;
            18:      return 21;
            19:      return 20;
            default: return 4;
        endcase
    endfunction

    // byte i of keyword k, counted from its first character
    function automatic logic [ByteW-1:0] kw_byte(input int k, input int i);
        logic [TextW-1:0] txt;
        txt = kw_text(k);
        return txt[(kw_len(k) - 1 - i) * ByteW +: ByteW];
    endfunction

endpackage

>>> rtl/gckm_team_digits.sv
// ============================================================================
// gckm_team_digits
// team number register and its four decimal digits
// ============================================================================
module gckm_team_digits (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [gckm_pkg::TeamW-1:0]        cfg_wr_data,
    output gckm_pkg::team_digits_t            team_digits
);

    logic [gckm_pkg::TeamW-1:0] team_reg;
    logic [gckm_pkg::TeamW-1:0] team_next;
    gckm_pkg::team_digits_t     digits_reg;
    gckm_pkg::team_digits_t     digits_next;

    // reciprocal products, exact for values below ten thousand
    logic [29:0] prod_tens;
    logic [26:0] prod_hund;
    logic [27:0] prod_thou;
    logic [9:0]  q_tens;
    logic [6:0]  q_hund;
    logic [3:0]  q_thou;

    always_comb begin
        team_next = team_reg;
        if (cfg_wr_en) begin
            // value is below twice the modulus, one subtract reduces it
            if (cfg_wr_data >= gckm_pkg::TeamModulus) begin
                team_next = cfg_wr_data - gckm_pkg::TeamModulus;
            end else begin
                team_next = cfg_wr_data;
            end
        end
    end

    always_comb begin
        prod_tens = 30'(team_reg) * 30'(52429);
        prod_hund = 27'(team_reg) * 27'(5243);
        prod_thou = 28'(team_reg) * 28'(8389);
        q_tens    = 10'(prod_tens >> 19);
        q_hund    = 7'(prod_hund >> 19);
        q_thou    = 4'(prod_thou >> 23);

        digits_next[0] = 4'(team_reg - 14'({4'd0, q_tens} * 14'd10));
        digits_next[1] = 4'(q_tens - 10'({3'd0, q_hund} * 10'd10));
        digits_next[2] = 4'(q_hund - 7'({3'd0, q_thou} * 7'd10));
        digits_next[3] = q_thou;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            team_reg   <= gckm_pkg::TeamReset;
            digits_reg <= {4'd1, 4'd0, 4'd0, 4'd8};
        end else begin
            team_reg   <= team_next;
            digits_reg <= digits_next;
        end
    end

    assign team_digits = digits_reg;

endmodule

>>> rtl/gckm_match.sv
// ============================================================================
// gckm_match
// byte window, parallel keyword comparators, sticky flags and priority code
// ============================================================================
module gckm_match #(
    parameter int LONGEST_KEYWORD = gckm_pkg::LongestKeywordDefault
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  gckm_pkg::gckm_step_t         step,
    input  logic [gckm_pkg::ByteW-1:0]   byte_in,
    input  gckm_pkg::team_digits_t       team_digits,
    output logic [gckm_pkg::CodeW-1:0]   command_code
);

    localparam int WinLen = LONGEST_KEYWORD;

    logic [WinLen-2:0][gckm_pkg::ByteW-1:0] recent_reg;
    logic [WinLen-2:0][gckm_pkg::ByteW-1:0] recent_next;
    logic [gckm_pkg::KwCount-1:0]           seen_reg;
    logic [gckm_pkg::KwCount-1:0]           seen_next;
    logic                                   ended_reg;
    logic                                   ended_next;

    logic [WinLen-1:0][gckm_pkg::ByteW-1:0] win;
    logic [gckm_pkg::KwCount-1:0]           hit;
    logic [gckm_pkg::KwCount-1:0]           seen_upd;
    logic                                   ended_now;
    logic                                   active;

    // newest byte at the top of the window
    assign win = {byte_in, recent_reg};

    genvar k, i;
    generate
        for (k = 0; k < gckm_pkg::KwCount; k++) begin : g_kw
            localparam int KwL = gckm_pkg::kw_len(k);
            if (KwL <= WinLen) begin : g_fits
                logic [KwL-1:0] eq;
                for (i = 0; i < KwL; i++) begin : g_pos
                    localparam bit IsDigit = (k < gckm_pkg::TeamKwCount) &&
                        (i >= gckm_pkg::TeamDigitPos) &&
                        (i < gckm_pkg::TeamDigitPos + gckm_pkg::DigitCount);
                    if (IsDigit) begin : g_dig
                        localparam int Di = gckm_pkg::TeamDigitPos +
                                            gckm_pkg::DigitCount - 1 - i;
                        assign eq[i] = (win[WinLen-KwL+i] ==
                                        {gckm_pkg::AsciiDigitHi, team_digits[Di]});
                    end else begin : g_chr
                        localparam logic [gckm_pkg::ByteW-1:0] Ch =
                            gckm_pkg::kw_byte(k, i);
                        assign eq[i] = (win[WinLen-KwL+i] == Ch);
                    end
                end
                assign hit[k] = &eq;
            end else begin : g_long
                // keyword longer than the window never matches
                assign hit[k] = 1'b0;
            end
        end
    endgenerate

    assign ended_now = ended_reg | (byte_in == gckm_pkg::ByteEnd);
    assign active    = !ended_now;
    assign seen_upd  = active ? (seen_reg | hit) : seen_reg;

    always_comb begin
        recent_next = recent_reg;
        seen_next   = seen_reg;
        ended_next  = ended_reg;
        if (step.advance) begin
            if (step.last) begin
                recent_next = '0;
                seen_next   = '0;
                ended_next  = 1'b0;
            end else begin
                ended_next = ended_now;
                seen_next  = seen_upd;
                if (active) begin
                    recent_next = win[WinLen-1:1];
                end
            end
        end
    end

    // lowest keyword number wins
    always_comb begin
        command_code = gckm_pkg::CodeNone;
        for (int n = gckm_pkg::KwCount - 1; n >= 0; n--) begin
            if (seen_upd[n]) begin
                command_code = gckm_pkg::CodeW'(n + 1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            recent_reg <= '0;
            seen_reg   <= '0;
            ended_reg  <= 1'b0;
        end else begin
            recent_reg <= recent_next;
            seen_reg   <= seen_next;
            ended_reg  <= ended_next;
        end
    end

endmodule

>>> rtl/ground_command_keyword_matcher.sv
// ============================================================================
// ground_command_keyword_matcher
// matches ground command keywords in received packet bytes
// ============================================================================
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------
//  s_       | in        | s_valid / s_ready  | s_packet_byte, s_final_byte
//  m_       | out       | m_valid / m_ready  | m_command_code
//  cfg_     | in        | cfg_wr_en only     | cfg_wr_data (team number)
//
// one byte per cycle sustained while no final byte waits; a byte passes
// through the input register, and its result (final byte only) is registered
// in the output register on m_; the input register frees as the byte moves on;
// only a final byte waits, and only while m_ still holds an untaken result
// synchronous active-low reset; team number resets to 1008, window and
// flags clear, no clearing pass
// a team number write passes the team and digit registers to the comparators
//
module ground_command_keyword_matcher #(
    parameter int LONGEST_KEYWORD = gckm_pkg::LongestKeywordDefault
) (
    input  logic                         aclk,
    input  logic                         aresetn,

    // team number register
    input  logic                         cfg_wr_en,
    input  logic [gckm_pkg::TeamW-1:0]   cfg_wr_data,

    // packet byte transactions
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [gckm_pkg::ByteW-1:0]   s_packet_byte,
    input  logic                         s_final_byte,

    // command code transactions
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [gckm_pkg::CodeW-1:0]   m_command_code
);

    // input register
    logic                        s1_valid_reg;
    logic                        s1_valid_next;
    logic [gckm_pkg::ByteW-1:0]  s1_byte_reg;
    logic                        s1_last_reg;

    // output register
    logic                        m_valid_reg;
    logic                        m_valid_next;
    logic [gckm_pkg::CodeW-1:0]  m_code_reg;

    logic                        s_accept;
    logic                        out_free;
    logic                        s1_advance;
    gckm_pkg::gckm_step_t        step;
    gckm_pkg::team_digits_t      team_digits;
    logic [gckm_pkg::CodeW-1:0]  match_code;

    // output slot can take a result this cycle
    assign out_free   = !m_valid_reg || m_ready;
    // non-final bytes never wait; final bytes need the output slot
    assign s1_advance = s1_valid_reg && (!s1_last_reg || out_free);
    assign s_ready    = !s1_valid_reg || s1_advance;
    assign s_accept   = s_valid && s_ready;

    assign step.advance = s1_advance;
    assign step.last    = s1_last_reg;

    gckm_team_digits u_team (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .team_digits (team_digits)
    );

    gckm_match #(
        .LONGEST_KEYWORD (LONGEST_KEYWORD)
    ) u_match (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (step),
        .byte_in      (s1_byte_reg),
        .team_digits  (team_digits),
        .command_code (match_code)
    );

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_advance) begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (s1_advance && s1_last_reg) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_byte_reg <= s_packet_byte;
            s1_last_reg <= s_final_byte;
        end
        if (s1_advance && s1_last_reg) begin
            m_code_reg <= match_code;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_command_code = m_code_reg;

endmodule

>>> test/ground_command_keyword_matcher_tb.sv
// ============================================================================
// ground_command_keyword_matcher_tb
// self-checking bench: packet bytes in, one command code per packet out
// ============================================================================
//
// a short table of hand-picked bytes runs first; codes that are obvious are
// typed into the table. Random packets follow, mostly built around real
// keywords, and they run under several team numbers. Every accepted byte goes
// through a local model of the matcher, and each final byte queues its typed code
// or else the code that the model predicts. The result side pops that queue in order and
// compares the code. Both sides drop their handshake at random, and once the
// result side holds off for a long stretch so that the input stalls.
//
module ground_command_keyword_matcher_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WindowLen = gckm_pkg::LongestKeywordDefault;
    localparam int PhaseBytes = 290;
    localparam int PhaseCount = 7;
    localparam int HoldCycles = 400;

    // keyword numbers in priority order; the command code is the number plus one
    typedef enum int unsigned {
        KwCxOn, KwCxOff, KwCal, KwSt, KwRls90, KwRls0, KwPrc90, KwPrc0,
        KwRhs, KwRfs, KwCf, KwUhs, KwChs, KwCamOn, KwCamOff, KwBuzOn,
        KwBuzOff, KwSimEnable, KwSimActivate, KwSimDisable, KwSimp
    } keyword_t;

    localparam logic [gckm_pkg::CodeW-1:0] CodeSimp = gckm_pkg::CodeW'(KwSimp + 1);

    // one directed byte; code is only meaningful when typed is set
    typedef struct packed {
        logic [gckm_pkg::ByteW-1:0] data;
        logic                       last;
        logic                       typed;
        logic [gckm_pkg::CodeW-1:0] code;
    } byte_row_t;

    localparam int DirRows = 22;
    localparam byte_row_t DirTable [DirRows] = '{
        // zero byte marked final, right after reset
        '{gckm_pkg::ByteEnd, 1'b1, 1'b1, gckm_pkg::CodeNone},
        // all-ones byte alone
        '{8'hFF,   1'b1, 1'b1, gckm_pkg::CodeNone},
        // shortest keyword, matched on the final byte itself
        '{"S",     1'b0, 1'b0, gckm_pkg::CodeNone},
        '{"I",     1'b0, 1'b0, gckm_pkg::CodeNone},
        '{"M",     1'b0, 1'b0, gckm_pkg::CodeNone},
        '{"P",     1'b1, 1'b1, CodeSimp},
        // flag stays set through trailing bytes
        '{"S",     1'b0, 1'b0, gckm_pkg::CodeNone},
        '{"I",     1'b0, 1'b0, gckm_pkg::CodeNone},
        '{"M",     1'b0, 1'b0, gckm_pkg::CodeNone},
        '{"P",     1'b0, 1'b0, gckm_pkg::CodeNone},
        '{"x",     1'b0, 1'b0, gckm_pkg::CodeNone},
        '{8'h7F,   1'b1, 1'b1, CodeSimp},
        // zero byte ends the text, keyword after it is ignored
        '{gckm_pkg::ByteEnd, 1'b0, 1'b0, gckm_pkg::CodeNone},
        '{"S",     1'b0, 1'b0, gckm_pkg::CodeNone},
        '{"I",     1'b0, 1'b0, gckm_pkg::CodeNone},
        '{"M",     1'b0, 1'b0, gckm_pkg::CodeNone},
        '{"P",     1'b1, 1'b1, gckm_pkg::CodeNone},
        // keyword before the zero byte still counts, zero byte is final
        '{"S",     1'b0, 1'b0, gckm_pkg::CodeNone},
        '{"I",     1'b0, 1'b0, gckm_pkg::CodeNone},
        '{"M",     1'b0, 1'b0, gckm_pkg::CodeNone},
        '{"P",     1'b0, 1'b0, gckm_pkg::CodeNone},
        '{gckm_pkg::ByteEnd, 1'b1, 1'b1, CodeSimp}
    };

    logic                       aclk;
    logic                       aresetn;
    logic                       cfg_wr_en;
    logic [gckm_pkg::TeamW-1:0] cfg_wr_data;
    logic                       s_valid;
    logic                       s_ready;
    logic [gckm_pkg::ByteW-1:0] s_packet_byte;
    logic                       s_final_byte;
    logic                       m_valid;
    logic                       m_ready;
    logic [gckm_pkg::CodeW-1:0] m_command_code;

    // matcher model state
    logic [gckm_pkg::TeamW-1:0]   team_now;
    logic [gckm_pkg::ByteW-1:0]   history [WindowLen-1];
    logic [gckm_pkg::KwCount-1:0] kw_seen;
    logic                         text_over;

    logic [gckm_pkg::CodeW-1:0] pending_codes [$];
    int               mismatches = 0;
    int               codes_checked = 0;
    int               bytes_sent;
    int               cycle_count = 0;

    // a window of cycles with no random idling on either side
    wire calm = (cycle_count >= 2000) && (cycle_count < 3500);

    ground_command_keyword_matcher #(
        .LONGEST_KEYWORD (WindowLen)
    ) DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_packet_byte  (s_packet_byte),
        .s_final_byte   (s_final_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_command_code (m_command_code)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // full text of keyword k under team number t
    function automatic string keyword_text(input int k,
                                           input logic [gckm_pkg::TeamW-1:0] t);
        string tail;
        case (k)
            KwCxOn:        tail = "CX,ON";
            KwCxOff:       tail = "CX,OFF";
            KwCal:         tail = "CAL";
            KwSt:          tail = "ST";
            KwRls90:       tail = "RLS90";
            KwRls0:        tail = "RLS0";
            KwPrc90:       tail = "PRC90";
            KwPrc0:        tail = "PRC0";
            KwRhs:         tail = "RHS";
            KwRfs:         tail = "RFS";
            KwCf:          tail = "CF";
            KwUhs:         tail = "UHS";
            KwChs:         tail = "CHS";
            KwCamOn:       tail = "CAM,ON";
            KwCamOff:      tail = "CAM,OFF";
            KwBuzOn:       tail = "BUZ,ON";
            KwBuzOff:      tail = "BUZ,OFF";
            KwSimEnable:   tail = "SIM,ENABLE";
            KwSimActivate: tail = "SIM,ACTIVATE";
            KwSimDisable:  tail = "SIM,DISABLE";
            default:       return "SIMP";
        endcase
        // digits of the team number modulo 10000
        return {"CMD,", $sformatf("%04d", int'(t) % 10000), ",", tail};
    endfunction

    function automatic void clear_packet();
        foreach (history[i]) history[i] = '0;
        kw_seen = '0;
        text_over = 1'b0;
    endfunction

    // advances the model by one byte; returns 1 when a code comes out
    function automatic bit match_byte(input logic [gckm_pkg::ByteW-1:0] data,
                                      input logic last,
                                      output logic [gckm_pkg::CodeW-1:0] code);
        logic [gckm_pkg::ByteW-1:0] win [WindowLen];
        string kw;
        int n;
        bit hit;
        code = gckm_pkg::CodeNone;
        if (data == gckm_pkg::ByteEnd) text_over = 1'b1;
        if (!text_over) begin
            for (int i = 0; i < WindowLen - 1; i++) win[i] = history[i];
            win[WindowLen-1] = data;
            for (int k = 0; k < gckm_pkg::KwCount; k++) begin
                kw = keyword_text(k, team_now);
                n = kw.len();
                // a keyword longer than the window can never match
                if (n <= WindowLen) begin
                    hit = 1'b1;
                    for (int i = 0; i < n; i++)
                        if (win[WindowLen-n+i] != kw[i]) hit = 1'b0;
                    if (hit) kw_seen[k] = 1'b1;
                end
            end
            for (int i = 0; i < WindowLen - 1; i++) history[i] = win[i+1];
        end
        if (!last) return 1'b0;
        // lowest keyword number wins
        for (int k = gckm_pkg::KwCount - 1; k >= 0; k--)
            if (kw_seen[k]) code = gckm_pkg::CodeW'(k + 1);
        clear_packet();
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what,
                                   input logic [gckm_pkg::CodeW-1:0] exp_code,
                                   input logic [gckm_pkg::CodeW-1:0] got_code);
        mismatches++;
        if (mismatches <= 10)
            $display("tb: %s at %0t: expected code %0d, got %0d",
                     what, $realtime, exp_code, got_code);
    endtask

    // offers one byte and waits for the transaction
    task automatic offer_byte(input logic [gckm_pkg::ByteW-1:0] data, input logic last,
                              input logic typed,
                              input logic [gckm_pkg::CodeW-1:0] typed_code);
        logic [gckm_pkg::CodeW-1:0] code;
        while (!calm && $urandom_range(99) < 6) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_packet_byte <= data;
        s_final_byte  <= last;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        bytes_sent++;
        if (match_byte(data, last, code))
            pending_codes.push_back(typed ? typed_code : code);
    endtask

    // one random packet, mostly keywords wrapped in noise
    task automatic send_packet();
        logic [gckm_pkg::ByteW-1:0] pkt [$];
        string kw;
        int kind;
        int n;
        int pos;
        kind = $urandom_range(99);
        if (kind < 70) begin
            repeat ($urandom_range(3))
                pkt.push_back(gckm_pkg::ByteW'($urandom_range(1, 255)));
            repeat ($urandom_range(1, 2)) begin
                // now and then the wrong team number
                kw = keyword_text($urandom_range(KwSimp),
                                  ($urandom_range(9) == 0) ? team_now + 1'b1 : team_now);
                n = kw.len();
                // truncated keyword
                if ($urandom_range(9) == 0) n = n - 1;
                pos = pkt.size();
                for (int i = 0; i < n; i++) pkt.push_back(kw[i]);
                // one damaged character
                if ($urandom_range(9) == 0)
                    pkt[pos + $urandom_range(n - 1)] = gckm_pkg::ByteW'($urandom_range(255));
            end
            repeat ($urandom_range(2))
                pkt.push_back(gckm_pkg::ByteW'($urandom_range(1, 255)));
            // end of text somewhere inside the packet
            if ($urandom_range(9) == 0)
                pkt.insert($urandom_range(pkt.size() - 1), gckm_pkg::ByteEnd);
        end else if (kind < 90) begin
            repeat ($urandom_range(1, 12))
                pkt.push_back(gckm_pkg::ByteW'($urandom_range(255)));
        end else begin
            pkt.push_back(gckm_pkg::ByteW'($urandom_range(255)));
        end
        foreach (pkt[i])
            offer_byte(pkt[i], i == pkt.size() - 1, 1'b0, gckm_pkg::CodeNone);
    endtask

    // result side: check each transaction, stall at random, one long hold-off
    initial begin
        int hold_left;
        bit held;
        logic [gckm_pkg::CodeW-1:0] exp_code;
        hold_left = 0;
        held = 1'b0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
                codes_checked++;
                if (pending_codes.size() == 0) begin
                    report_mismatch("unexpected code", gckm_pkg::CodeNone, m_command_code);
                end else begin
                    exp_code = pending_codes.pop_front();
                    if (m_command_code !== exp_code)
                        report_mismatch("code mismatch", exp_code, m_command_code);
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!held && codes_checked == 40) begin
                // long hold-off while bytes keep coming
                held = 1'b1;
                hold_left = HoldCycles;
                m_ready <= 1'b0;
            end else begin
                m_ready <= calm || ($urandom_range(99) >= 6);
            end
        end
    end

    // main sequence
    initial begin
        logic [gckm_pkg::TeamW-1:0] team_plan [PhaseCount-1];
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_valid       = 1'b0;
        s_packet_byte = '0;
        s_final_byte  = 1'b0;
        bytes_sent    = 0;
        team_now      = gckm_pkg::TeamReset;
        clear_packet();
        // extremes, then values above 9999 and random ones, then back to reset
        team_plan = '{gckm_pkg::TeamW'(0), gckm_pkg::TeamW'(9999),
                      gckm_pkg::TeamW'(16383), gckm_pkg::TeamW'($urandom_range(9999)),
                      gckm_pkg::TeamW'($urandom_range(16383)), gckm_pkg::TeamReset};

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < DirRows; r++)
            offer_byte(DirTable[r].data, DirTable[r].last, DirTable[r].typed,
                       DirTable[r].code);

        for (int p = 0; p < PhaseCount; p++) begin
            if (p > 0) begin
                // idle first: every code back, then let the pipe drain
                s_valid <= 1'b0;
                while (pending_codes.size() != 0) @(posedge aclk);
                repeat (4) @(posedge aclk);
                cfg_wr_en   <= 1'b1;
                cfg_wr_data <= team_plan[p-1];
                @(posedge aclk);
                cfg_wr_en <= 1'b0;
                team_now = team_plan[p-1];
                // new digits pass through the team and digit registers before they reach the comparators
                repeat (3) @(posedge aclk);
            end
            bytes_sent = 0;
            while (bytes_sent < PhaseBytes) send_packet();
        end

        s_valid <= 1'b0;
        while (pending_codes.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // run limit
    initial begin
        #3_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

>>> files.f
rtl/gckm_pkg.sv
rtl/gckm_team_digits.sv
rtl/gckm_match.sv
rtl/ground_command_keyword_matcher.sv
test/ground_command_keyword_matcher_tb.sv
